### sv/tmrp_pkg.sv
package tmrp_pkg;

    localparam int G_W    = 32;
    localparam int COF_W  = 65;
    localparam int TERM_W = 97;
    localparam int DET_W  = 99;
    localparam int NUM_W  = 102;
    localparam int DEN_W  = 102;
    localparam int PROD_W = 134;
    localparam int QUO_W  = 33;

    localparam int DIV_LAT = QUO_W + 1;

    localparam int IX_XX = 0;
    localparam int IX_XY = 1;
    localparam int IX_XZ = 2;
    localparam int IX_YY = 3;
    localparam int IX_YZ = 4;
    localparam int IX_ZZ = 5;

    typedef logic [5:0][G_W-1:0] t_sym;

    typedef struct packed {
        logic ovf;
        logic neg;
    } t_div_flags;

endpackage

### sv/tmrp_mul.sv
module tmrp_mul #(
    parameter int AW = 65
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [31:0]   i_b,
    output logic signed [AW+31:0] o_p
);

    localparam int NC = (AW + 31) / 32;
    localparam int EW = NC * 32;
    localparam int OW = AW + 32;

    logic signed [EW-1:0] a_ext;
    logic signed [64:0]   n_pp [NC];
    logic signed [64:0]   r_pp [NC];
    logic signed [OW-1:0] n_sum;

    assign a_ext = EW'(i_a);

    always_comb begin
        for (int j = 0; j < NC; j++) begin
            if (j == NC - 1) begin
                n_pp[j] = $signed({a_ext[EW-1], a_ext[j*32 +: 32]}) * i_b;
            end else begin
                n_pp[j] = $signed({1'b0, a_ext[j*32 +: 32]}) * i_b;
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < NC; j++) begin
            n_sum = n_sum + (OW'(r_pp[j]) <<< (32 * j));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NC; j++) begin
            r_pp[j] <= n_pp[j];
        end
        o_p <= n_sum;
    end

endmodule

### sv/tmrp_div.sv
module tmrp_div import tmrp_pkg::*; (
    input  logic              i_clk,
    input  logic [PROD_W-1:0] i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic              i_neg,
    output logic [QUO_W-1:0]  o_quo,
    output t_div_flags        o_flags
);

    logic [PROD_W-1:0] r_rem [0:QUO_W-1];
    logic [DEN_W-1:0]  r_dv  [0:QUO_W-1];
    logic [QUO_W-1:0]  r_q   [0:QUO_W];
    t_div_flags        r_fl  [0:QUO_W];

    always_ff @(posedge i_clk) begin
        r_rem[0]    <= i_num;
        r_dv[0]     <= i_den;
        r_q[0]      <= '0;
        r_fl[0].ovf <= (PROD_W+2)'(i_num) >= ((PROD_W+2)'(i_den) << QUO_W);
        r_fl[0].neg <= i_neg;
    end

    for (genvar i = 1; i <= QUO_W; i++) begin : g_step
        logic [PROD_W:0] trial;
        assign trial = {1'b0, r_rem[i-1]} - ((PROD_W+1)'(r_dv[i-1]) << (QUO_W - i));

        always_ff @(posedge i_clk) begin
            r_q[i]  <= r_q[i-1] | (trial[PROD_W] ? '0 : (QUO_W'(1) << (QUO_W - i)));
            r_fl[i] <= r_fl[i-1];
        end

        if (i < QUO_W) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_rem[i] <= trial[PROD_W] ? r_rem[i-1] : trial[PROD_W-1:0];
                r_dv[i]  <= r_dv[i-1];
            end
        end
    end

    assign o_quo   = r_q[QUO_W];
    assign o_flags = r_fl[QUO_W];

endmodule

### sv/traceless_metric_rate_projection.sv
// channel   | direction | handshake                      | payload
// request   | in        | start, busy (busy always low)  | i_metric_*, i_rate_*
// result    | out       | o_result_strobe, one cycle     | o_fixed_*, o_singular_flag
// config    | in        | i_cfg_valid, o_cfg_ready       | i_cfg_data (projection enable)
//
// One request per cycle; each request passes through the multiply stages and then the
// 34-stage quotient pipeline before its result is registered onto the ports.
// Reset clears the enable register and all valid bits; results in flight are dropped.
// The receiver cannot stall, so the pipeline always advances and busy stays low.
module traceless_metric_rate_projection import tmrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic [31:0] i_metric_xx,
    input  logic [31:0] i_metric_xy,
    input  logic [31:0] i_metric_xz,
    input  logic [31:0] i_metric_yy,
    input  logic [31:0] i_metric_yz,
    input  logic [31:0] i_metric_zz,
    input  logic [31:0] i_rate_xx,
    input  logic [31:0] i_rate_xy,
    input  logic [31:0] i_rate_xz,
    input  logic [31:0] i_rate_yy,
    input  logic [31:0] i_rate_yz,
    input  logic [31:0] i_rate_zz,
    output logic        o_result_strobe,
    output logic [31:0] o_fixed_xx,
    output logic [31:0] o_fixed_xy,
    output logic [31:0] o_fixed_xz,
    output logic [31:0] o_fixed_yy,
    output logic [31:0] o_fixed_yz,
    output logic [31:0] o_fixed_zz,
    output logic        o_singular_flag
);

    localparam int L_OUT = 8 + DIV_LAT;
    localparam int L_SNG = L_OUT - 6;

    logic r_enable;

    t_sym r_gp [0:5];
    t_sym r_dp [0:L_OUT];
    logic r_vp [0:L_OUT];
    logic r_ep [0:L_OUT];
    logic r_sp [0:L_SNG];

    logic signed [63:0]       r_pa [6];
    logic signed [63:0]       r_pb [6];
    logic signed [COF_W-1:0]  r_cof [6];
    logic signed [TERM_W-1:0] det_t [3];
    logic signed [TERM_W-1:0] num_t [6];
    logic signed [DET_W-1:0]  r_det;
    logic signed [NUM_W-1:0]  r_num;
    logic signed [DEN_W-1:0]  r_den;
    logic signed [DEN_W-1:0]  r_den2;
    logic signed [PROD_W-1:0] prod [6];
    logic [PROD_W-1:0]        r_pabs [6];
    logic                     r_pneg [6];
    logic [DEN_W-1:0]         r_dabs;
    logic [QUO_W-1:0]         quo [6];
    t_div_flags               dfl [6];

    logic signed [31:0] g0, g1, g2, g3, g4, g5;
    logic [5:0][31:0]   n_fixed;
    logic               n_sing;
    logic               r_out_v;
    logic [5:0][31:0]   r_fixed;
    logic               r_sing;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_enable <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= L_OUT; s++) begin
                r_vp[s] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else begin
            r_vp[0] <= start;
            for (int s = 1; s <= L_OUT; s++) begin
                r_vp[s] <= r_vp[s-1];
            end
            r_out_v <= r_vp[L_OUT];
        end
    end

    always_ff @(posedge i_clk) begin
        r_gp[0] <= {i_metric_zz, i_metric_yz, i_metric_yy,
                    i_metric_xz, i_metric_xy, i_metric_xx};
        r_dp[0] <= {i_rate_zz, i_rate_yz, i_rate_yy, i_rate_xz, i_rate_xy, i_rate_xx};
        r_ep[0] <= r_enable;
        r_sp[0] <= (r_det == '0);
        for (int s = 1; s <= 5; s++) begin
            r_gp[s] <= r_gp[s-1];
        end
        for (int s = 1; s <= L_OUT; s++) begin
            r_dp[s] <= r_dp[s-1];
            r_ep[s] <= r_ep[s-1];
        end
        for (int s = 1; s <= L_SNG; s++) begin
            r_sp[s] <= r_sp[s-1];
        end
    end

    assign g0 = $signed(r_gp[0][IX_XX]);
    assign g1 = $signed(r_gp[0][IX_XY]);
    assign g2 = $signed(r_gp[0][IX_XZ]);
    assign g3 = $signed(r_gp[0][IX_YY]);
    assign g4 = $signed(r_gp[0][IX_YZ]);
    assign g5 = $signed(r_gp[0][IX_ZZ]);

    always_ff @(posedge i_clk) begin
        r_pa[IX_XX] <= g3 * g5;
        r_pb[IX_XX] <= g4 * g4;
        r_pa[IX_XY] <= g2 * g4;
        r_pb[IX_XY] <= g1 * g5;
        r_pa[IX_XZ] <= g1 * g4;
        r_pb[IX_XZ] <= g2 * g3;
        r_pa[IX_YY] <= g0 * g5;
        r_pb[IX_YY] <= g2 * g2;
        r_pa[IX_YZ] <= g1 * g2;
        r_pb[IX_YZ] <= g0 * g4;
        r_pa[IX_ZZ] <= g0 * g3;
        r_pb[IX_ZZ] <= g1 * g1;
        for (int k = 0; k < 6; k++) begin
            r_cof[k] <= COF_W'(r_pa[k]) - COF_W'(r_pb[k]);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_det
        tmrp_mul #(.AW(COF_W)) u_mul (
            .i_clk (i_clk),
            .i_a   (r_cof[k]),
            .i_b   ($signed(r_gp[2][k])),
            .o_p   (det_t[k])
        );
    end

    for (genvar k = 0; k < 6; k++) begin : g_num
        tmrp_mul #(.AW(COF_W)) u_mul (
            .i_clk (i_clk),
            .i_a   (r_cof[k]),
            .i_b   ($signed(r_dp[2][k])),
            .o_p   (num_t[k])
        );
    end

    always_ff @(posedge i_clk) begin
        r_det <= DET_W'(det_t[0]) + DET_W'(det_t[1]) + DET_W'(det_t[2]);
        r_num <= NUM_W'(num_t[IX_XX]) + (NUM_W'(num_t[IX_XY]) <<< 1)
               + (NUM_W'(num_t[IX_XZ]) <<< 1) + NUM_W'(num_t[IX_YY])
               + (NUM_W'(num_t[IX_YZ]) <<< 1) + NUM_W'(num_t[IX_ZZ]);
        r_den  <= DEN_W'(r_det) + (DEN_W'(r_det) <<< 1);
        r_den2 <= r_den;
        r_dabs <= r_den2[DEN_W-1] ? DEN_W'(-r_den2) : DEN_W'(r_den2);
        for (int k = 0; k < 6; k++) begin
            r_pabs[k] <= prod[k][PROD_W-1] ? PROD_W'(-prod[k]) : PROD_W'(prod[k]);
            r_pneg[k] <= prod[k][PROD_W-1] ^ r_den2[DEN_W-1];
        end
    end

    for (genvar k = 0; k < 6; k++) begin : g_lane
        tmrp_mul #(.AW(NUM_W)) u_mul (
            .i_clk (i_clk),
            .i_a   (r_num),
            .i_b   ($signed(r_gp[5][k])),
            .o_p   (prod[k])
        );

        tmrp_div u_div (
            .i_clk   (i_clk),
            .i_num   (r_pabs[k]),
            .i_den   (r_dabs),
            .i_neg   (r_pneg[k]),
            .o_quo   (quo[k]),
            .o_flags (dfl[k])
        );
    end

    always_comb begin
        logic signed [QUO_W+1:0] qs;
        logic signed [QUO_W+1:0] diff;
        n_sing = r_ep[L_OUT] & r_sp[L_SNG];
        for (int k = 0; k < 6; k++) begin
            qs   = dfl[k].neg ? -$signed({2'b00, quo[k]}) : $signed({2'b00, quo[k]});
            diff = (QUO_W+2)'($signed(r_dp[L_OUT][k])) - qs;
            if (!r_ep[L_OUT] || r_sp[L_SNG]) begin
                n_fixed[k] = r_dp[L_OUT][k];
            end else if (dfl[k].ovf) begin
                n_fixed[k] = dfl[k].neg ? 32'h7FFF_FFFF : 32'h8000_0000;
            end else if (diff > (QUO_W+2)'(32'sh7FFF_FFFF)) begin
                n_fixed[k] = 32'h7FFF_FFFF;
            end else if (diff < (QUO_W+2)'(32'sh8000_0000)) begin
                n_fixed[k] = 32'h8000_0000;
            end else begin
                n_fixed[k] = diff[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fixed <= n_fixed;
        r_sing  <= n_sing;
    end

    assign o_result_strobe = r_out_v;
    assign o_fixed_xx      = r_fixed[IX_XX];
    assign o_fixed_xy      = r_fixed[IX_XY];
    assign o_fixed_xz      = r_fixed[IX_XZ];
    assign o_fixed_yy      = r_fixed[IX_YY];
    assign o_fixed_yz      = r_fixed[IX_YZ];
    assign o_fixed_zz      = r_fixed[IX_ZZ];
    assign o_singular_flag = r_sing;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vp[L_OUT] |=> o_result_strobe)
        else $error("result strobe missing for a request in flight");

    a_pass_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vp[L_OUT] && !r_ep[L_OUT]) |=>
            (o_fixed_xx == $past(r_dp[L_OUT][IX_XX])) && !o_singular_flag)
        else $error("disabled projection altered the rate");

    a_flag_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vp[L_OUT] && r_ep[L_OUT] && r_sp[L_SNG]) |=>
            o_singular_flag && (o_fixed_zz == $past(r_dp[L_OUT][IX_ZZ])))
        else $error("singular metric did not pass the rate through");

endmodule
